[hdl/nhw_pkg.sv]
// nhw_pkg: shared types and constants for the network hang watchdog
// item structs, status and mode codes, register indexes and reset values
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nhw_pkg;

    // register indexes on the configuration port
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_INTERVAL  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESTART_TIMEOUT = 1'd1;

    localparam logic [31:0] CHECK_INTERVAL_RST  = 32'd120000;
    localparam logic [31:0] RESTART_TIMEOUT_RST = 32'd1200000;

    localparam logic [15:0] CNT_MAX = 16'hffff;

    typedef enum logic [1:0] {
        MODE_POLL    = 2'd0,
        MODE_ENABLE  = 2'd1,
        MODE_DISABLE = 2'd2
    } nhw_mode_t;

    typedef enum logic [1:0] {
        REQ_SENT  = 2'd0,
        REQ_NOMEM = 2'd1
    } nhw_req_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOMEM   = 3'd1,
        ST_PENDING = 3'd2,
        ST_STALLED = 3'd3,
        ST_CLOSED  = 3'd4,
        ST_TIMEOUT = 3'd5,
        ST_REQFAIL = 3'd6
    } nhw_status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic        ip_present;
        logic [31:0] rx_block_count;
        logic        gw_arp_found;
        logic        gw_arp_stable;
        logic        buffer_available;
        logic [1:0]  arp_request_result;
    } nhw_in_t;

    typedef struct packed {
        logic [2:0]  returned_status;
        logic [2:0]  recorded_status;
        logic        network_ok;
        logic        check_done;
        logic        restart_flag;
        logic        link_up;
        logic        rx_stalled;
        logic [15:0] buffer_fail_count;
    } nhw_out_t;

    typedef struct packed {
        logic        monitor_enabled;
        logic        link_is_up;
        logic        restart_pending;
        logic [31:0] last_check_time;
        logic [31:0] gateway_ok_time;
        logic [31:0] receive_ok_time;
        logic [31:0] last_rx_count;
        logic [15:0] stall_checks;
        logic [15:0] nomem_checks;
        nhw_status_t status_code;
    } nhw_state_t;

    localparam nhw_state_t STATE_RST = '{
        monitor_enabled: 1'b0,
        link_is_up:      1'b0,
        restart_pending: 1'b0,
        last_check_time: 32'd0,
        gateway_ok_time: 32'd0,
        receive_ok_time: 32'd0,
        last_rx_count:   32'd0,
        stall_checks:    16'd0,
        nomem_checks:    16'd0,
        status_code:     ST_OK
    };

endpackage

`default_nettype wire

[hdl/nhw_eval.sv]
// nhw_eval: health check logic for one event item
// next watchdog state and result item from current state and registers
// depends on nhw_pkg
`timescale 1ns / 1ps
`default_nettype none

module nhw_eval (
    input  wire nhw_pkg::nhw_state_t state_cur,
    input  wire nhw_pkg::nhw_in_t    item,
    input  wire logic [31:0]    check_interval_ms,
    input  wire logic [31:0]    restart_timeout_ms,
    output nhw_pkg::nhw_state_t state_nxt,
    output nhw_pkg::nhw_out_t   result
);
    import nhw_pkg::*;

    logic [31:0] since_check;
    logic [31:0] back_one_interval;

    assign since_check       = item.now_ms - state_cur.last_check_time;
    assign back_one_interval = item.now_ms - check_interval_ms;

    always_comb begin
        nhw_state_t  st;
        logic        done;
        logic        want;
        logic        timed_out;
        logic [31:0] gw_gap;
        logic [31:0] rx_gap;
        nhw_status_t ret;

        st        = state_cur;
        done      = 1'b0;
        want      = 1'b0;
        timed_out = 1'b0;
        gw_gap    = '0;
        rx_gap    = '0;
        ret       = ST_OK;

        case (item.mode)
            MODE_ENABLE, MODE_DISABLE: begin
                want = (item.mode == MODE_ENABLE);
                if (state_cur.monitor_enabled != want) begin
                    st.monitor_enabled = want;
                    st.last_check_time = back_one_interval;
                    st.link_is_up      = 1'b0;
                    st.gateway_ok_time = item.now_ms;
                    st.restart_pending = 1'b0;
                    st.last_rx_count   = item.rx_block_count;
                    st.stall_checks    = '0;
                    st.receive_ok_time = item.now_ms;
                end
            end
            MODE_POLL: begin
                if (state_cur.monitor_enabled && since_check >= check_interval_ms) begin
                    done               = 1'b1;
                    st.last_check_time = item.now_ms;
                    st.status_code     = ST_OK;
                    if (state_cur.link_is_up) begin
                        if (item.ip_present) begin
                            if (item.rx_block_count == state_cur.last_rx_count) begin
                                if (state_cur.stall_checks != CNT_MAX) begin
                                    st.stall_checks = state_cur.stall_checks + 16'd1;
                                end
                            end else begin
                                st.last_rx_count   = item.rx_block_count;
                                st.stall_checks    = '0;
                                st.receive_ok_time = item.now_ms;
                            end
                            if (item.gw_arp_found) begin
                                if (item.gw_arp_stable) begin
                                    st.gateway_ok_time = item.now_ms;
                                end
                                if (!item.buffer_available) begin
                                    st.status_code = ST_NOMEM;
                                end
                            end else if (item.arp_request_result == REQ_SENT) begin
                                st.status_code = ST_PENDING;
                            end else if (item.arp_request_result == REQ_NOMEM) begin
                                st.status_code = ST_NOMEM;
                            end else begin
                                st.status_code = ST_REQFAIL;
                            end
                            if (st.status_code == ST_NOMEM &&
                                state_cur.nomem_checks != CNT_MAX) begin
                                st.nomem_checks = state_cur.nomem_checks + 16'd1;
                            end
                            if (st.status_code == ST_OK && st.stall_checks != '0) begin
                                st.status_code = ST_STALLED;
                            end
                        end else begin
                            st.link_is_up  = 1'b0;
                            st.status_code = ST_CLOSED;
                        end
                    end else if (item.ip_present) begin
                        // link comes up: restart the progress clocks
                        st.link_is_up      = 1'b1;
                        st.gateway_ok_time = item.now_ms;
                        st.restart_pending = 1'b0;
                        st.last_check_time = back_one_interval;
                        st.last_rx_count   = '0;
                        st.stall_checks    = '0;
                        st.receive_ok_time = item.now_ms;
                    end

                    gw_gap    = item.now_ms - st.gateway_ok_time;
                    rx_gap    = item.now_ms - st.receive_ok_time;
                    timed_out = (gw_gap > restart_timeout_ms) ||
                                (rx_gap > restart_timeout_ms);
                    if (timed_out) begin
                        st.restart_pending = 1'b1;
                        if (st.status_code == ST_OK) begin
                            st.status_code = ST_TIMEOUT;
                        end
                        ret = st.status_code;
                    end
                end
            end
            default: begin
            end
        endcase

        state_nxt                = st;
        result.returned_status   = ret;
        result.recorded_status   = st.status_code;
        result.network_ok        = (ret == ST_OK);
        result.check_done        = done;
        result.restart_flag      = st.restart_pending;
        result.link_up           = st.link_is_up;
        result.rx_stalled        = (st.stall_checks != '0);
        result.buffer_fail_count = st.nomem_checks;
    end

endmodule

`default_nettype wire

[hdl/network_hang_watchdog.sv]
// network_hang_watchdog: top level, input register, watchdog state, result register
// depends on nhw_pkg and nhw_eval
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    nhw_in_t  event item
//   m_        out        m_valid / m_ready    nhw_out_t result item
//   cfg_      in         cfg_wr_en            cfg_addr, cfg_wdata
//
// one item per cycle while m_ready is high; m_valid follows in_valid_reg
// the check is combinational between the input register and the result register,
// and the watchdog state is updated in the same cycle so the next item sees it
// aresetn (synchronous, active low) clears the state and restores register defaults
// a stalled m_ready holds the result register; the input register still takes one item
`timescale 1ns / 1ps
`default_nettype none

module network_hang_watchdog (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire nhw_pkg::nhw_in_t              s_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output nhw_pkg::nhw_out_t                  m_item,
    input  wire logic                          cfg_wr_en,
    input  wire logic [nhw_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [nhw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import nhw_pkg::*;

    logic        in_valid_reg;
    nhw_in_t     in_item_reg;
    logic        out_valid_reg;
    nhw_out_t    out_item_reg;
    nhw_state_t  state_reg;
    nhw_state_t  state_next;
    nhw_out_t    result_next;
    logic [31:0] interval_reg;
    logic [31:0] timeout_reg;
    logic        advance;
    logic        process;

    assign advance = !out_valid_reg || m_ready;
    assign process = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    nhw_eval u_eval (
        .state_cur          (state_reg),
        .item               (in_item_reg),
        .check_interval_ms  (interval_reg),
        .restart_timeout_ms (timeout_reg),
        .state_nxt          (state_next),
        .result             (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= CHECK_INTERVAL_RST;
            timeout_reg  <= RESTART_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_CHECK_INTERVAL:  interval_reg <= cfg_wdata;
                CFG_RESTART_TIMEOUT: timeout_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RST;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (process) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (process) begin
            out_item_reg <= result_next;
        end
    end

    // a nonzero returned status only comes from a check that timed out
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.returned_status != ST_OK |->
            m_item.restart_flag && m_item.check_done &&
            m_item.returned_status == m_item.recorded_status)
        else $error("returned status without a timed-out check");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.network_ok == (m_item.returned_status == ST_OK))
        else $error("network_ok disagrees with returned status");

    // a poll while the monitor is off never counts as a check
    assert property (@(posedge aclk) disable iff (!aresetn)
        process && !state_reg.monitor_enabled |=> !m_item.check_done)
        else $error("check done while monitor disabled");

    // state only moves when an item is processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !process |=> $stable(state_reg))
        else $error("watchdog state changed without an item");

endmodule

`default_nettype wire
